// ===== rtl/segment_box_slab_clip_defines.svh =====
// ----------------------------------------------------------------------------
// segment_box_slab_clip_defines
// Assertion macros for the slab clipper; they expand to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef SEGMENT_BOX_SLAB_CLIP_DEFINES_SVH
`define SEGMENT_BOX_SLAB_CLIP_DEFINES_SVH

`ifndef SYNTHESIS
// clocked check, off while reset is applied
`define SBSC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// clocked check, also during reset
`define SBSC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SBSC_ASSERT(lbl, prop, msg)
`define SBSC_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== rtl/sbsc_pkg.sv =====
// ----------------------------------------------------------------------------
// sbsc_pkg
// Widths, constants, word types and sequencer states of the slab clipper.
// ----------------------------------------------------------------------------
package sbsc_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int COORD_WIDTH = 32;
    localparam int TOL_WIDTH   = 31;

    localparam int WIDE_W  = (COORD_WIDTH > TOL_WIDTH) ? COORD_WIDTH : TOL_WIDTH;
    localparam int SLAB_W  = WIDE_W + 2;
    localparam int NUM_W   = WIDE_W + 3;
    localparam int DLT_W   = COORD_WIDTH + 1;
    localparam int REM_W   = NUM_W + 1;
    localparam int T_W     = FRAC_BITS + 3;
    localparam int Q_W     = FRAC_BITS + 2;
    localparam int OUT_T_W = FRAC_BITS + 1;

    // divider steps: two integer bits, overflow check, then the fraction bits
    localparam int DIV_STEPS   = FRAC_BITS + 3;
    localparam int STEP_W      = $clog2(DIV_STEPS);
    localparam int STEP_INT_HI = 0;
    localparam int STEP_OVF    = 2;
    localparam int STEP_LAST   = DIV_STEPS - 1;

    localparam logic signed [T_W-1:0] T_ONE     = (T_W)'(1 << FRAC_BITS);
    localparam logic signed [T_W-1:0] T_TWO     = (T_W)'(2 << FRAC_BITS);
    localparam logic signed [T_W-1:0] T_NEG_ONE = -T_ONE;
    localparam logic signed [T_W-1:0] T_ZERO    = '0;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] start_coord;
        logic signed [COORD_WIDTH-1:0] end_coord;
        logic signed [COORD_WIDTH-1:0] box_low;
        logic signed [COORD_WIDTH-1:0] box_high;
        logic                          last_dim;
    } sbsc_in_t;

    typedef struct packed {
        logic               hit;
        logic [OUT_T_W-1:0] t_enter;
        logic [OUT_T_W-1:0] t_exit;
    } sbsc_out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_LOAD,
        ST_MAG,
        ST_DIV,
        ST_STORE,
        ST_FOLD,
        ST_DONE
    } sbsc_state_t;

endpackage

// ===== rtl/segment_box_slab_clip.sv =====
// ----------------------------------------------------------------------------
// segment_box_slab_clip
// Slab clip of a segment against a tolerance-widened axis-aligned box.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready/in_word carry one dimension per word: both endpoint
//   coordinates, the box bounds and a last_dim mark. Dimensions accumulate
//   into a running entry/exit range; the word with last_dim set produces
//   one result word (hit, t_enter, t_exit) on out_valid/out_ready.
//   cfg_we/cfg_data load the tolerance; write it only while idle.
//   A dimension with nonzero delta takes two quotients in turn on one
//   restoring divider, one bit per cycle; a quotient of four or more
//   saturates and skips its fraction bits. Zero delta or an already
//   rejected run bypasses the divider. The result word appears as the
//   sequencer returns to idle; in_ready is high only in idle.
//   Reset clears the running range, the reject flag, the tolerance and the
//   output register. If the receiver stalls, the result waits in the output
//   register; the next box can be taken meanwhile and its last dimension
//   waits until that register is free.
// ----------------------------------------------------------------------------
`include "segment_box_slab_clip_defines.svh"

module segment_box_slab_clip
    import sbsc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  sbsc_in_t             in_word,
    output logic                 out_valid,
    input  logic                 out_ready,
    output sbsc_out_t            out_word,
    input  logic                 cfg_we,
    input  logic [TOL_WIDTH-1:0] cfg_data
);

    sbsc_state_t state_reg, state_next;

    logic [TOL_WIDTH-1:0]          tol_reg;
    logic signed [COORD_WIDTH-1:0] a_reg, a_next;
    logic signed [SLAB_W-1:0]      lo_reg, lo_next;
    logic signed [SLAB_W-1:0]      hi_reg, hi_next;
    logic signed [DLT_W-1:0]       dlt_reg, dlt_next;
    logic                          last_reg, last_next;
    logic signed [NUM_W-1:0]       num_reg, num_next;
    logic                          sel_reg, sel_next;
    logic                          neg_reg, neg_next;
    logic [DLT_W-1:0]              d_reg, d_next;
    logic [REM_W-1:0]              rem_reg, rem_next;
    logic [Q_W-1:0]                q_reg, q_next;
    logic [STEP_W-1:0]             step_reg, step_next;
    logic                          sat_reg, sat_next;
    logic signed [T_W-1:0]         t0_reg, t0_next;
    logic signed [T_W-1:0]         t1_reg, t1_next;
    logic signed [T_W-1:0]         enter_reg, enter_next;
    logic signed [T_W-1:0]         exit_reg, exit_next;
    logic                          rej_reg, rej_next;
    logic                          out_valid_reg, out_valid_next;
    sbsc_out_t                     out_reg, out_next;

    logic signed [SLAB_W-1:0] tol_ext;
    logic signed [SLAB_W-1:0] a_ext;
    logic signed [SLAB_W-1:0] slab_sel;
    logic                     out_free;

    // shared divider datapath
    logic                     frac_phase;
    logic [REM_W-1:0]         op_r;
    logic [REM_W-1:0]         dsel;
    logic [REM_W:0]           diff;
    logic                     ge;

    logic signed [T_W-1:0]    q_s;
    logic signed [T_W-1:0]    t_val;
    logic signed [T_W-1:0]    t_lo;
    logic signed [T_W-1:0]    t_hi;
    logic signed [T_W-1:0]    new_enter;
    logic signed [T_W-1:0]    new_exit;
    logic signed [T_W-1:0]    clip_lo;
    logic signed [T_W-1:0]    clip_hi;
    logic                     fin_hit;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_word  = out_reg;
    assign out_free  = !out_valid_reg || out_ready;

    assign tol_ext  = $signed(SLAB_W'(tol_reg));
    assign a_ext    = SLAB_W'(a_reg);
    assign slab_sel = sel_reg ? hi_reg : lo_reg;

    assign frac_phase = (step_reg > STEP_W'(STEP_OVF));
    assign op_r       = frac_phase ? {rem_reg[REM_W-2:0], 1'b0} : rem_reg;
    assign dsel       = (step_reg == STEP_W'(STEP_INT_HI)) ? REM_W'({d_reg, 1'b0})
                                                           : REM_W'(d_reg);
    assign diff       = {1'b0, op_r} - {1'b0, dsel};
    assign ge         = !diff[REM_W];

    assign q_s = $signed(T_W'(q_reg));

    always_comb
    begin
        if (sat_reg)
        begin
            t_val = neg_reg ? T_NEG_ONE : T_TWO;
        end
        else if (neg_reg)
        begin
            t_val = (q_s > T_ONE) ? T_NEG_ONE : -q_s;
        end
        else
        begin
            t_val = (q_s > T_TWO) ? T_TWO : q_s;
        end
    end

    assign t_lo      = (t0_reg > t1_reg) ? t1_reg : t0_reg;
    assign t_hi      = (t0_reg > t1_reg) ? t0_reg : t1_reg;
    assign new_enter = (t_lo > enter_reg) ? t_lo : enter_reg;
    assign new_exit  = (t_hi < exit_reg) ? t_hi : exit_reg;

    assign clip_lo = (enter_reg < T_ZERO) ? T_ZERO : enter_reg;
    assign clip_hi = (exit_reg > T_ONE) ? T_ONE : exit_reg;
    assign fin_hit = !rej_reg && (clip_lo <= clip_hi);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            tol_reg       <= '0;
            a_reg         <= '0;
            lo_reg        <= '0;
            hi_reg        <= '0;
            dlt_reg       <= '0;
            last_reg      <= 1'b0;
            num_reg       <= '0;
            sel_reg       <= 1'b0;
            neg_reg       <= 1'b0;
            d_reg         <= '0;
            rem_reg       <= '0;
            q_reg         <= '0;
            step_reg      <= '0;
            sat_reg       <= 1'b0;
            t0_reg        <= '0;
            t1_reg        <= '0;
            enter_reg     <= T_ZERO;
            exit_reg      <= T_ONE;
            rej_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            if (cfg_we)
            begin
                tol_reg <= cfg_data;
            end
            a_reg         <= a_next;
            lo_reg        <= lo_next;
            hi_reg        <= hi_next;
            dlt_reg       <= dlt_next;
            last_reg      <= last_next;
            num_reg       <= num_next;
            sel_reg       <= sel_next;
            neg_reg       <= neg_next;
            d_reg         <= d_next;
            rem_reg       <= rem_next;
            q_reg         <= q_next;
            step_reg      <= step_next;
            sat_reg       <= sat_next;
            t0_reg        <= t0_next;
            t1_reg        <= t1_next;
            enter_reg     <= enter_next;
            exit_reg      <= exit_next;
            rej_reg       <= rej_next;
            out_valid_reg <= out_valid_next;
            out_reg       <= out_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        a_next         = a_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        dlt_next       = dlt_reg;
        last_next      = last_reg;
        num_next       = num_reg;
        sel_next       = sel_reg;
        neg_next       = neg_reg;
        d_next         = d_reg;
        rem_next       = rem_reg;
        q_next         = q_reg;
        step_next      = step_reg;
        sat_next       = sat_reg;
        t0_next        = t0_reg;
        t1_next        = t1_reg;
        enter_next     = enter_reg;
        exit_next      = exit_reg;
        rej_next       = rej_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_next       = out_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    a_next     = in_word.start_coord;
                    lo_next    = SLAB_W'(in_word.box_low) - tol_ext;
                    hi_next    = SLAB_W'(in_word.box_high) + tol_ext;
                    dlt_next   = DLT_W'(in_word.end_coord) - DLT_W'(in_word.start_coord);
                    last_next  = in_word.last_dim;
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                if (rej_reg)
                begin
                    state_next = ST_DONE;
                end
                else if (dlt_reg == '0)
                begin
                    if (a_ext < lo_reg || a_ext > hi_reg)
                    begin
                        rej_next = 1'b1;
                    end
                    state_next = ST_DONE;
                end
                else
                begin
                    d_next     = dlt_reg[DLT_W-1] ? DLT_W'(-dlt_reg) : DLT_W'(dlt_reg);
                    sel_next   = 1'b0;
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                num_next   = NUM_W'(slab_sel) - NUM_W'(a_reg);
                state_next = ST_MAG;
            end
            ST_MAG:
            begin
                neg_next   = num_reg[NUM_W-1] ^ dlt_reg[DLT_W-1];
                rem_next   = num_reg[NUM_W-1] ? REM_W'(-num_reg) : REM_W'(num_reg);
                q_next     = '0;
                step_next  = '0;
                sat_next   = 1'b0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (step_reg == STEP_W'(STEP_OVF))
                begin
                    // integer part of four or more saturates
                    if (ge)
                    begin
                        sat_next   = 1'b1;
                        state_next = ST_STORE;
                    end
                    else
                    begin
                        step_next = step_reg + 1'b1;
                    end
                end
                else
                begin
                    rem_next = ge ? diff[REM_W-1:0] : op_r;
                    q_next   = {q_reg[Q_W-2:0], ge};
                    if (step_reg == STEP_W'(STEP_LAST))
                    begin
                        state_next = ST_STORE;
                    end
                    else
                    begin
                        step_next = step_reg + 1'b1;
                    end
                end
            end
            ST_STORE:
            begin
                if (!sel_reg)
                begin
                    t0_next    = t_val;
                    sel_next   = 1'b1;
                    state_next = ST_LOAD;
                end
                else
                begin
                    t1_next    = t_val;
                    state_next = ST_FOLD;
                end
            end
            ST_FOLD:
            begin
                enter_next = new_enter;
                exit_next  = new_exit;
                if (new_enter > new_exit)
                begin
                    rej_next = 1'b1;
                end
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!last_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    out_next.hit     = fin_hit;
                    out_next.t_enter = fin_hit ? clip_lo[OUT_T_W-1:0] : '0;
                    out_next.t_exit  = fin_hit ? clip_hi[OUT_T_W-1:0] : '0;
                    enter_next       = T_ZERO;
                    exit_next        = T_ONE;
                    rej_next         = 1'b0;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `SBSC_ASSERT(a_out_from_done,
        (out_valid_reg && !$past(out_valid_reg)) |-> $past(state_reg == ST_DONE && last_reg),
        "result word not loaded from a finished last dimension")
    `SBSC_ASSERT(a_enter_range,
        (enter_reg >= T_NEG_ONE) && (enter_reg <= T_TWO),
        "running entry out of saturation range")
    `SBSC_ASSERT(a_hit_order,
        (out_valid_reg && out_reg.hit) |-> ((out_reg.t_enter <= out_reg.t_exit)
            && (out_reg.t_exit <= OUT_T_W'(1 << FRAC_BITS))),
        "hit word with unordered range")
    `SBSC_ASSERT(a_miss_zero,
        (out_valid_reg && !out_reg.hit) |-> ((out_reg.t_enter == '0) && (out_reg.t_exit == '0)),
        "miss word with nonzero range")
    `SBSC_ASSERT(a_run_cleared,
        (state_reg == ST_DONE && last_reg && out_free) |=> (state_reg == ST_IDLE && !rej_reg
            && enter_reg == T_ZERO && exit_reg == T_ONE),
        "run state not cleared after last dimension")
    `SBSC_ASSERT_ALWAYS(a_reset_idle,
        !rst_n |=> (!out_valid_reg && state_reg == ST_IDLE),
        "reset did not clear the sequencer and output")

endmodule
